// ----- rtl/core/aglr_pkg.sv -----
// Shared widths, constants and register indexes of the linear gain ramp block.
package aglr_pkg;

  localparam int GAIN_FRAC_BITS = 16;
  localparam int INT_FRAC       = 32;
  localparam int GAIN_SHIFT     = INT_FRAC - GAIN_FRAC_BITS;
  localparam int TARGET_W       = 20;
  localparam int GAIN_W         = TARGET_W + GAIN_SHIFT;
  localparam int DIFF_W         = GAIN_W + 1;
  localparam int RATE_W         = 16;
  localparam int CHAN_W         = 5;
  localparam int FRAMES_W       = RATE_W + DIFF_W - INT_FRAC;
  localparam int LO_W           = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 20;

  localparam logic signed [GAIN_W-1:0] UNIT_GAIN      = GAIN_W'(64'd1 << INT_FRAC);
  localparam logic signed [DIFF_W-1:0] GAIN_THRESHOLD = DIFF_W'(85899);

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(32'd1 << GAIN_FRAC_BITS);
  localparam logic [RATE_W-1:0]   RATE_RESET   = RATE_W'(2400);
  localparam logic [CHAN_W-1:0]   CHAN_RESET   = CHAN_W'(2);

  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNELS = 2'd2;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// ----- rtl/core/aglr_queue.sv -----
// Short register queue between the front and the back of the gain block.
module aglr_queue #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [WIDTH-1:0]      push_data,
  input  logic                  pop,
  output logic [WIDTH-1:0]      pop_data,
  output aglr_pkg::q_status_t   status
);
  import aglr_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign status.valid = (count != '0);
  assign status.full  = (count == CW'(DEPTH));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && status.valid;
  assign pop_data     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/aglr_front.sv -----
// Input side: accepts items and marks the first sample of each frame.
module aglr_front #(
  parameter int MAX_CHANNELS = 16,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [aglr_pkg::CHAN_W-1:0]       channel_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     sample_in,
  input  logic                              block_start,
  input  aglr_pkg::q_status_t               q_status,
  output logic                              push,
  output logic [SAMPLE_BITS+1:0]            push_data
);
  import aglr_pkg::*;

  localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam logic [7:0] MaxCount = 8'(MAX_CHANNELS);

  logic [PW-1:0] position;
  logic [7:0]    count_ext;
  logic [7:0]    frame_len;
  logic [PW-1:0] pos_eff;
  logic [7:0]    pos_inc;
  logic          frame_start;

  assign count_ext = 8'(channel_count);

  always_comb begin
    if (channel_count == '0) begin
      frame_len = 8'd1;
    end else if (count_ext > MaxCount) begin
      frame_len = MaxCount;
    end else begin
      frame_len = count_ext;
    end
    pos_eff     = (block_start || (8'(position) >= frame_len)) ? '0 : position;
    frame_start = (pos_eff == '0);
    pos_inc     = 8'(pos_eff) + 8'd1;
  end

  assign in_ready  = !q_status.full;
  assign push      = in_valid && in_ready;
  assign push_data = {sample_in, block_start, frame_start};

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      position <= (pos_inc >= frame_len) ? '0 : pos_inc[PW-1:0];
    end
  end

endmodule

// ----- rtl/core/aglr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp increment.
module aglr_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [aglr_pkg::DIFF_W-1:0]     dividend,
  input  logic [aglr_pkg::FRAMES_W-1:0]   divisor,
  output logic                            done,
  output logic [aglr_pkg::DIFF_W-1:0]     quotient
);
  import aglr_pkg::*;

  localparam int CntW = $clog2(DIFF_W + 1);

  logic                busy;
  logic [CntW-1:0]     cnt;
  logic [FRAMES_W-1:0] rem;
  logic [FRAMES_W-1:0] dvs;
  logic [DIFF_W-1:0]   quo;
  logic [FRAMES_W:0]   trial;
  logic [FRAMES_W:0]   trial_sub;
  logic                fits;

  assign trial     = {rem, quo[DIFF_W-1]};
  assign trial_sub = trial - {1'b0, dvs};
  assign fits      = (trial >= {1'b0, dvs});
  assign quotient  = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(DIFF_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial_sub[FRAMES_W-1:0] : trial[FRAMES_W-1:0];
      quo <= {quo[DIFF_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/core/aglr_back.sv -----
// Work side: gain and ramp state, sample multiply, rounding, saturation, output register.
module aglr_back #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [aglr_pkg::TARGET_W-1:0]     gain_target,
  input  logic [aglr_pkg::RATE_W-1:0]       ramp_frames_per_unit_gain,
  input  aglr_pkg::q_status_t               q_status,
  input  logic [SAMPLE_BITS+1:0]            q_data,
  output logic                              q_pop,
  output logic                              div_start,
  output logic [aglr_pkg::DIFF_W-1:0]       div_dividend,
  output logic [aglr_pkg::FRAMES_W-1:0]     div_divisor,
  input  logic                              div_done,
  input  logic [aglr_pkg::DIFF_W-1:0]       div_quotient,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     sample_out,
  output logic                              ramping
);
  import aglr_pkg::*;

  localparam int AccW  = SAMPLE_BITS + GAIN_W;
  localparam int LoPW  = SAMPLE_BITS + LO_W + 1;
  localparam int HiPW  = SAMPLE_BITS + GAIN_W - LO_W;
  localparam logic signed [AccW-1:0] RoundHalf =
    {{(AccW-INT_FRAC){1'b0}}, 1'b1, {(INT_FRAC-1){1'b0}}};
  localparam logic signed [AccW-1:0] SatMax =
    {{(AccW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin = ~SatMax;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FRAMES = 8'b0000_0010,
    S_FRCHK  = 8'b0000_0100,
    S_DIV    = 8'b0000_1000,
    S_STEP   = 8'b0001_0000,
    S_MUL    = 8'b0010_0000,
    S_MUL2   = 8'b0100_0000,
    S_FIN    = 8'b1000_0000
  } state_t;

  state_t                       state;
  logic signed [GAIN_W-1:0]     gain;
  logic signed [GAIN_W-1:0]     ramp_step;
  logic [FRAMES_W-1:0]          frames_left;
  logic                         initialized;
  logic signed [GAIN_W-1:0]     held_target;
  logic                         frame_is_ramp;
  logic                         snap_pending;
  logic signed [DIFF_W-1:0]     diff;
  logic [FRAMES_W-1:0]          frames;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [LoPW-1:0]       p_lo;
  logic signed [HiPW-1:0]       p_hi;
  logic signed [AccW-1:0]       part;
  logic                         bypass;
  logic                         mute;

  logic signed [SAMPLE_BITS-1:0] q_sample;
  logic                         q_bs;
  logic                         q_fs;
  logic signed [GAIN_W-1:0]     tgt_int;
  logic signed [GAIN_W-1:0]     base;
  logic signed [GAIN_W-1:0]     step_base;
  logic signed [GAIN_W-1:0]     stepped;
  logic signed [DIFF_W-1:0]     diff_next;
  logic [DIFF_W-1:0]            mag;
  logic [RATE_W+DIFF_W-1:0]     prod;
  logic [DIFF_W-1:0]            quo_signed;
  logic signed [DIFF_W-1:0]     unit_dist;
  logic signed [DIFF_W-1:0]     gain_ext;
  logic signed [AccW-1:0]       total;
  logic signed [AccW-1:0]       shifted;
  logic signed [SAMPLE_BITS-1:0] sat_val;
  logic signed [SAMPLE_BITS-1:0] result;
  logic                         ramp_go;
  logic                         can_load;

  assign q_sample   = q_data[SAMPLE_BITS+1:2];
  assign q_bs       = q_data[1];
  assign q_fs       = q_data[0];
  assign tgt_int    = {gain_target, {GAIN_SHIFT{1'b0}}};
  assign base       = (q_fs && snap_pending) ? held_target : gain;
  assign step_base  = (state == S_STEP) ? gain : base;
  assign stepped    = step_base + ramp_step;
  assign diff_next  = DIFF_W'(tgt_int) - DIFF_W'(base);
  assign mag        = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod       = (RATE_W+DIFF_W)'(ramp_frames_per_unit_gain) * (RATE_W+DIFF_W)'(mag);
  assign quo_signed = diff[DIFF_W-1] ? -div_quotient : div_quotient;
  assign gain_ext   = DIFF_W'(gain);
  assign unit_dist  = gain_ext - DIFF_W'(UNIT_GAIN);
  assign ramp_go    = (frames_left != '0);
  assign can_load   = !out_valid || out_ready;
  assign q_pop      = (state == S_IDLE) && q_status.valid;

  assign div_start    = (state == S_FRCHK) && (frames != '0);
  assign div_dividend = mag;
  assign div_divisor  = frames;

  always_comb begin
    total   = AccW'(p_hi) + part;
    shifted = total >>> (INT_FRAC - LO_W);
    if (shifted > SatMax) begin
      sat_val = SatMax[SAMPLE_BITS-1:0];
    end else if (shifted < SatMin) begin
      sat_val = SatMin[SAMPLE_BITS-1:0];
    end else begin
      sat_val = shifted[SAMPLE_BITS-1:0];
    end
    if (frame_is_ramp) begin
      result = sat_val;
    end else if (bypass) begin
      result = sample;
    end else if (mute) begin
      result = '0;
    end else begin
      result = sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      gain          <= UNIT_GAIN;
      ramp_step     <= '0;
      frames_left   <= '0;
      initialized   <= 1'b0;
      held_target   <= UNIT_GAIN;
      frame_is_ramp <= 1'b0;
      snap_pending  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_status.valid) begin
            sample <= q_sample;
            if (q_fs && snap_pending) begin
              snap_pending <= 1'b0;
            end
            if (q_bs) begin
              held_target <= tgt_int;
              frames_left <= '0;
              initialized <= 1'b1;
              if (!initialized) begin
                gain  <= tgt_int;
                state <= S_STEP;
              end else if (base != tgt_int) begin
                gain  <= base;
                diff  <= diff_next;
                state <= S_FRAMES;
              end else begin
                gain  <= base;
                state <= S_STEP;
              end
            end else begin
              if (q_fs) begin
                frame_is_ramp <= ramp_go;
                if (ramp_go) begin
                  gain        <= stepped;
                  frames_left <= frames_left - 1'b1;
                  if (frames_left == FRAMES_W'(1)) begin
                    snap_pending <= 1'b1;
                  end
                end else begin
                  gain <= base;
                end
              end
              state <= S_MUL;
            end
          end
        end
        S_FRAMES: begin
          frames <= prod[INT_FRAC +: FRAMES_W];
          state  <= S_FRCHK;
        end
        S_FRCHK: begin
          state <= (frames != '0) ? S_DIV : S_STEP;
        end
        S_DIV: begin
          if (div_done) begin
            ramp_step   <= quo_signed[GAIN_W-1:0];
            frames_left <= frames;
            state       <= S_STEP;
          end
        end
        S_STEP: begin
          frame_is_ramp <= ramp_go;
          if (ramp_go) begin
            gain        <= stepped;
            frames_left <= frames_left - 1'b1;
            if (frames_left == FRAMES_W'(1)) begin
              snap_pending <= 1'b1;
            end
          end
          state <= S_MUL;
        end
        S_MUL: begin
          p_lo   <= LoPW'(sample) * LoPW'($signed({1'b0, gain[LO_W-1:0]}));
          bypass <= (unit_dist <= GAIN_THRESHOLD) && (unit_dist >= -GAIN_THRESHOLD);
          mute   <= (gain_ext <= GAIN_THRESHOLD) && (gain_ext >= -GAIN_THRESHOLD);
          state  <= S_MUL2;
        end
        S_MUL2: begin
          p_hi  <= HiPW'(sample) * HiPW'($signed(gain[GAIN_W-1:LO_W]));
          part  <= (AccW'(p_lo) + RoundHalf) >>> LO_W;
          state <= S_FIN;
        end
        S_FIN: begin
          if (can_load) begin
            sample_out <= result;
            ramping    <= frame_is_ramp;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_snap_no_frames: assert property (@(posedge clk) disable iff (rst)
    snap_pending |-> frames_left == '0)
    else $error("snap pending while ramp frames remain");
  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");
  a_mul_entry: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> $past(state) == S_IDLE || $past(state) == S_STEP)
    else $error("multiply entered without a gain update");
`endif

endmodule

// ----- rtl/core/audio_gain_linear_ramp_top.sv -----
// Top level of the linear gain ramp: configuration registers, front, queue, back, divider.
// Each sample is multiplied by a gain held with 32 fraction bits, rounded half up and
// saturated; outside a ramp a gain near unity passes the sample, one near zero mutes it.
// A queued item passes the back's sequencer: entry and gain update, the low and high
// partial-product multiply, and the result, held until the output register is free; the
// front keeps filling the queue while it has room. A block start also passes the step
// state, a target change the frame-count multiply and check, a ramp start a restoring
// divider giving one of 37 quotient bits per cycle. There is no clearing pass after reset.
module audio_gain_linear_ramp_top #(
  parameter int MAX_CHANNELS = 16,
  parameter int SAMPLE_BITS  = 24,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [aglr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [aglr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  input  logic                                 block_start,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        sample_out,
  output logic                                 ramping
);
  import aglr_pkg::*;

  logic [TARGET_W-1:0]     gain_target;
  logic [RATE_W-1:0]       ramp_frames_per_unit_gain;
  logic [CHAN_W-1:0]       channel_count;
  q_status_t               q_status;
  logic                    push;
  logic [SAMPLE_BITS+1:0]  push_data;
  logic                    pop;
  logic [SAMPLE_BITS+1:0]  pop_data;
  logic                    div_start;
  logic [DIFF_W-1:0]       div_dividend;
  logic [FRAMES_W-1:0]     div_divisor;
  logic                    div_done;
  logic [DIFF_W-1:0]       div_quotient;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_target               <= TARGET_RESET;
      ramp_frames_per_unit_gain <= RATE_RESET;
      channel_count             <= CHAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET:   gain_target               <= cfg_data[TARGET_W-1:0];
        CFG_RATE:     ramp_frames_per_unit_gain <= cfg_data[RATE_W-1:0];
        CFG_CHANNELS: channel_count             <= cfg_data[CHAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  aglr_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .channel_count (channel_count),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .sample_in     (sample_in),
    .block_start   (block_start),
    .q_status      (q_status),
    .push          (push),
    .push_data     (push_data)
  );

  aglr_queue #(
    .WIDTH (SAMPLE_BITS + 2),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  aglr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  aglr_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                       (clk),
    .rst                       (rst),
    .gain_target               (gain_target),
    .ramp_frames_per_unit_gain (ramp_frames_per_unit_gain),
    .q_status                  (q_status),
    .q_data                    (pop_data),
    .q_pop                     (pop),
    .div_start                 (div_start),
    .div_dividend              (div_dividend),
    .div_divisor               (div_divisor),
    .div_done                  (div_done),
    .div_quotient              (div_quotient),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .sample_out                (sample_out),
    .ramping                   (ramping)
  );

endmodule
